// ----- hw/rtl/piecewise_linear_lut_eval_macros.svh -----
// Assertion macros for the piecewise-linear LUT evaluator.
// Used by files that assert; expects clk_i and rst_ni in scope.
`ifndef PIECEWISE_LINEAR_LUT_EVAL_MACROS_SVH
`define PIECEWISE_LINEAR_LUT_EVAL_MACROS_SVH

// Generic clocked assertion with an active-low reset.
`define PWL_ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) else $error(msg);

// Assertion on the block clock and reset.
`define PWL_ASSERT(lbl, prop, msg) `PWL_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- hw/rtl/pwl_lut_pkg.sv -----
// Package for the piecewise-linear LUT evaluator: widths, opcodes, node type.
// No dependencies.
`timescale 1ns / 1ps

package pwl_lut_pkg;

  localparam int unsigned IdxW          = 9;
  localparam int unsigned PosW          = 16;
  localparam int unsigned ColW          = 8;
  localparam int unsigned SlotW         = 4;
  localparam int unsigned CountW        = 5;
  localparam int unsigned NumCh         = 4;
  localparam int unsigned MaxNodesDef   = 16;
  localparam int unsigned TableWidthDef = 512;
  localparam int unsigned MinNodes      = 2;
  localparam int unsigned RecipShift    = 24;
  localparam int unsigned NumW          = 24;
  localparam int unsigned QuoW          = 8;

  localparam logic [PosW-1:0]   PosOne     = 16'hFFFF;
  localparam logic [ColW-1:0]   ColFull    = 8'hFF;
  localparam logic [CountW-1:0] CountReset = 5'd2;

  typedef enum logic {
    OpLoad = 1'b0,
    OpEval = 1'b1
  } op_e;

  typedef logic [ColW-1:0] col_t;

  typedef struct packed {
    logic [PosW-1:0]        pos;
    col_t [NumCh-1:0]       col;
  } node_t;

  localparam int unsigned NodeW = $bits(node_t);

  // Reset content of a node slot: slot 1 is white at 1.0, all others zero.
  function automatic node_t node_reset(logic is_one);
    node_t n;
    n = '0;
    if (is_one) begin
      n.pos = PosOne;
      n.col = {NumCh{ColFull}};
    end
    return n;
  endfunction

endpackage

// ----- hw/rtl/piecewise_linear_lut_eval.sv -----
// One item per cycle while the output is not stalled; loads give no result.
// Stages: index scale, node search, store read, setup, multiply, add, divide (4).
// Node store write and read happen in order in the pipe, so loads and evaluates never race.
// Reset (rst_ni low, async) clears valids and node_count to 2; node 0 black at 0, node 1 white.
// Depends on pwl_lut_pkg, pwl_lut_ram and piecewise_linear_lut_eval_macros.svh.
`timescale 1ns / 1ps
`include "piecewise_linear_lut_eval_macros.svh"

module piecewise_linear_lut_eval #(
  parameter int unsigned MaxNodes   = pwl_lut_pkg::MaxNodesDef,
  parameter int unsigned TableWidth = pwl_lut_pkg::TableWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pwl_lut_pkg::CountW-1:0]   cfg_node_count_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             opcode_i,
  input  logic [pwl_lut_pkg::SlotW-1:0]    node_slot_i,
  input  logic [pwl_lut_pkg::PosW-1:0]     node_pos_i,
  input  logic [pwl_lut_pkg::ColW-1:0]     node_red_i,
  input  logic [pwl_lut_pkg::ColW-1:0]     node_green_i,
  input  logic [pwl_lut_pkg::ColW-1:0]     node_blue_i,
  input  logic [pwl_lut_pkg::ColW-1:0]     node_alpha_i,
  input  logic [pwl_lut_pkg::IdxW-1:0]     entry_index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pwl_lut_pkg::IdxW-1:0]     out_index_o,
  output logic [pwl_lut_pkg::ColW-1:0]     out_red_o,
  output logic [pwl_lut_pkg::ColW-1:0]     out_green_o,
  output logic [pwl_lut_pkg::ColW-1:0]     out_blue_o,
  output logic [pwl_lut_pkg::ColW-1:0]     out_alpha_o
);

  import pwl_lut_pkg::*;

  localparam int unsigned AddrW  = $clog2(MaxNodes);
  localparam int unsigned CntW   = $clog2(MaxNodes + 1);
  localparam int unsigned Div    = TableWidth - 1;
  localparam int unsigned PW     = 21;
  localparam int unsigned IqW    = 25;
  localparam int unsigned RecW   = 25;
  localparam int unsigned DivW   = 12;
  localparam logic [PosW-1:0] TQuot  = PosW'(65535 / Div);
  localparam logic [DivW-1:0] TRem   = DivW'(65535 % Div);
  localparam logic [RecW-1:0] TRecip = RecW'((64'd1 << RecipShift) / Div);
  localparam logic [DivW-1:0] TDiv   = DivW'(Div);
  localparam int unsigned NumStg = 14;
  localparam int unsigned StgE   = 4;
  localparam int unsigned StgF   = 5;
  localparam int unsigned StgH   = 7;
  localparam int unsigned DivStg = 4;

  // configuration
  logic [CountW-1:0] cfg_q;
  logic [CntW-1:0]   n_act;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CountReset;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_node_count_i;
    end
  end

  always_comb begin
    if (32'(cfg_q) < MinNodes) begin
      n_act = CntW'(MinNodes);
    end else if (32'(cfg_q) > MaxNodes) begin
      n_act = CntW'(MaxNodes);
    end else begin
      n_act = CntW'(cfg_q);
    end
  end

  // pipeline control
  logic              adv;
  logic              in_fire;
  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] vld_d;

  // stage payload
  op_e               a_op_q, b_op_q, c_op_q, d_op_q, e_op_q;
  logic [SlotW-1:0]  a_slot_q, b_slot_q, c_slot_q, d_slot_q, e_slot_q;
  node_t             a_node_q, b_node_q, c_node_q, d_node_q, e_node_q;
  logic [IdxW-1:0]   a_idx_q, b_idx_q, c_idx_q, d_idx_q, e_idx_q, f_idx_q, g_idx_q;
  logic [IdxW-1:0]   h_idx_q, i_idx_q, j_idx_q;
  logic [PW-1:0]     b_p_q, c_p_q, d_p_q;
  logic [IqW-1:0]    b_iq_q, c_iq_q, d_iq_q;
  logic [IdxW-1:0]   c_q0_q, d_q0_q;
  logic [PW-1:0]     d_qd_q;
  logic [PosW-1:0]   e_t_q, f_t_q, g_t_q;
  logic [MaxNodes-2:0] f_hit_q;
  logic [MaxNodes-2:0] f_hit_d;
  logic [AddrW-1:0]  g_k_q;
  logic              g_va_q, g_vb_q;
  logic [PosW-1:0]   h_d_q, h_x_q, h_dmx_q, i_d_q, j_d_q;
  col_t [NumCh-1:0]  h_ca_q, h_cb_q;
  logic [NumW-1:0]   i_m1_q [NumCh];
  logic [NumW-1:0]   i_m2_q [NumCh];
  logic [NumW-1:0]   j_num_q [NumCh];
  logic [NumW-1:0]   k_rem_q [DivStg][NumCh];
  logic [NumW-1:0]   k_rem_d [DivStg][NumCh];
  logic [QuoW-1:0]   k_quo_q [DivStg][NumCh];
  logic [QuoW-1:0]   k_quo_d [DivStg][NumCh];
  logic [PosW-1:0]   k_d_q [DivStg];
  logic [IdxW-1:0]   k_idx_q [DivStg];

  // node store
  logic [PosW-1:0]     pos_q [MaxNodes];
  logic [MaxNodes-1:0] wr_q;
  logic                st_we;
  logic [AddrW-1:0]    st_waddr;
  logic [AddrW-1:0]    k_sel;
  logic [AddrW-1:0]    k_nxt;
  node_t               rd_a, rd_b;
  logic [NodeW-1:0]    rd_a_raw, rd_b_raw;

  assign adv        = !vld_q[NumStg-1] || out_ready_i;
  assign in_ready_o = adv;
  assign in_fire    = in_valid_i && adv;

  always_comb begin
    vld_d       = {vld_q[NumStg-2:0], in_fire};
    vld_d[StgF] = vld_q[StgE] && (e_op_q == OpEval);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // index scaling: t = idx*Q + floor(idx*R/Div), saturated
  logic [PW+RecW-1:0] c_prod;
  logic [PW-1:0]      e_rem;
  logic [IdxW:0]      e_q;
  logic [IqW:0]       e_sum;

  assign c_prod = (PW+RecW)'(b_p_q) * (PW+RecW)'(TRecip);
  assign e_rem  = d_p_q - d_qd_q;
  assign e_q    = (IdxW+1)'(d_q0_q) + (IdxW+1)'(e_rem >= PW'(TDiv));
  assign e_sum  = (IqW+1)'(d_iq_q) + (IqW+1)'(e_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_op_q   <= op_e'(opcode_i);
      a_slot_q <= node_slot_i;
      a_node_q <= {node_pos_i, node_alpha_i, node_blue_i, node_green_i, node_red_i};
      a_idx_q  <= entry_index_i;

      b_op_q   <= a_op_q;
      b_slot_q <= a_slot_q;
      b_node_q <= a_node_q;
      b_idx_q  <= a_idx_q;
      b_p_q    <= PW'(a_idx_q) * PW'(TRem);
      b_iq_q   <= IqW'(a_idx_q) * IqW'(TQuot);

      c_op_q   <= b_op_q;
      c_slot_q <= b_slot_q;
      c_node_q <= b_node_q;
      c_idx_q  <= b_idx_q;
      c_p_q    <= b_p_q;
      c_iq_q   <= b_iq_q;
      c_q0_q   <= c_prod[RecipShift +: IdxW];

      d_op_q   <= c_op_q;
      d_slot_q <= c_slot_q;
      d_node_q <= c_node_q;
      d_idx_q  <= c_idx_q;
      d_p_q    <= c_p_q;
      d_iq_q   <= c_iq_q;
      d_q0_q   <= c_q0_q;
      d_qd_q   <= PW'(c_q0_q) * PW'(TDiv);

      e_op_q   <= d_op_q;
      e_slot_q <= d_slot_q;
      e_node_q <= d_node_q;
      e_idx_q  <= d_idx_q;
      e_t_q    <= (e_sum > (IqW+1)'(PosOne)) ? PosOne : e_sum[PosW-1:0];
    end
  end

  // store write from a load in stage E
  assign st_we    = vld_q[StgE] && adv && (e_op_q == OpLoad) && (32'(e_slot_q) < MaxNodes);
  assign st_waddr = AddrW'(e_slot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < MaxNodes; s++) begin
        pos_q[s] <= (s == 1) ? PosOne : '0;
      end
      wr_q <= '0;
    end else if (st_we) begin
      pos_q[st_waddr] <= e_node_q.pos;
      wr_q[st_waddr]  <= 1'b1;
    end
  end

  // segment search
  always_comb begin
    for (int j = 0; j < MaxNodes - 1; j++) begin
      f_hit_d[j] = (32'(j) + 32'd1 < 32'(n_act)) && (e_t_q <= pos_q[j+1]);
    end
  end

  always_comb begin
    k_sel = AddrW'(32'(n_act) - MinNodes);
    for (int j = MaxNodes - 2; j >= 0; j--) begin
      if (f_hit_q[j]) begin
        k_sel = AddrW'(j);
      end
    end
    k_nxt = k_sel + AddrW'(1);
  end

  pwl_lut_ram #(
    .Width(NodeW),
    .Depth(MaxNodes)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (st_we),
    .waddr_i   (st_waddr),
    .wdata_i   (e_node_q),
    .re_i      (adv),
    .raddr_a_i (k_sel),
    .raddr_b_i (k_nxt),
    .rdata_a_o (rd_a_raw),
    .rdata_b_o (rd_b_raw)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_hit_q <= f_hit_d;
      f_t_q   <= e_t_q;
      f_idx_q <= e_idx_q;

      g_k_q   <= k_sel;
      g_va_q  <= wr_q[k_sel];
      g_vb_q  <= wr_q[k_nxt];
      g_t_q   <= f_t_q;
      g_idx_q <= f_idx_q;
    end
  end

  // segment setup
  logic [PosW-1:0] h_d, h_x;
  logic            h_empty;

  assign rd_a = g_va_q ? node_t'(rd_a_raw) : node_reset(g_k_q == AddrW'(1));
  assign rd_b = g_vb_q ? node_t'(rd_b_raw) : node_reset(g_k_q == AddrW'(0));

  always_comb begin
    h_empty = rd_b.pos <= rd_a.pos;
    h_d     = rd_b.pos - rd_a.pos;
    h_x     = (g_t_q <= rd_a.pos) ? '0 : (g_t_q - rd_a.pos);
    if (h_x > h_d) begin
      h_x = h_d;
    end
    // empty segment: divide cb*1 by 1
    if (h_empty) begin
      h_d = PosW'(1);
      h_x = PosW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_d_q   <= h_d;
      h_x_q   <= h_x;
      h_dmx_q <= h_d - h_x;
      h_ca_q  <= rd_a.col;
      h_cb_q  <= rd_b.col;
      h_idx_q <= g_idx_q;

      for (int c = 0; c < NumCh; c++) begin
        i_m1_q[c]  <= NumW'(h_ca_q[c]) * NumW'(h_dmx_q);
        i_m2_q[c]  <= NumW'(h_cb_q[c]) * NumW'(h_x_q);
        j_num_q[c] <= i_m1_q[c] + i_m2_q[c];
      end
      i_d_q   <= h_d_q;
      i_idx_q <= h_idx_q;
      j_d_q   <= i_d_q;
      j_idx_q <= i_idx_q;
    end
  end

  // restoring divide, two quotient bits per stage
  always_comb begin
    logic [NumW-1:0] rem;
    logic [NumW-1:0] dsh;
    logic [QuoW-1:0] quo;
    logic [PosW-1:0] dv;
    int              bi;
    for (int s = 0; s < DivStg; s++) begin
      for (int c = 0; c < NumCh; c++) begin
        rem = (s == 0) ? j_num_q[c] : k_rem_q[(s == 0) ? 0 : s-1][c];
        quo = (s == 0) ? '0 : k_quo_q[(s == 0) ? 0 : s-1][c];
        dv  = (s == 0) ? j_d_q : k_d_q[(s == 0) ? 0 : s-1];
        for (int b = 0; b < 2; b++) begin
          bi  = QuoW - 1 - 2*s - b;
          dsh = NumW'(dv) << bi;
          if (rem >= dsh) begin
            rem     = rem - dsh;
            quo[bi] = 1'b1;
          end
        end
        k_rem_d[s][c] = rem;
        k_quo_d[s][c] = quo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < DivStg; s++) begin
        for (int c = 0; c < NumCh; c++) begin
          k_rem_q[s][c] <= k_rem_d[s][c];
          k_quo_q[s][c] <= k_quo_d[s][c];
        end
        k_d_q[s]   <= (s == 0) ? j_d_q : k_d_q[(s == 0) ? 0 : s-1];
        k_idx_q[s] <= (s == 0) ? j_idx_q : k_idx_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign out_valid_o = vld_q[NumStg-1];
  assign out_index_o = k_idx_q[DivStg-1];
  assign out_red_o   = k_quo_q[DivStg-1][0];
  assign out_green_o = k_quo_q[DivStg-1][1];
  assign out_blue_o  = k_quo_q[DivStg-1][2];
  assign out_alpha_o = k_quo_q[DivStg-1][3];

  `PWL_ASSERT(a_stall_hold, !adv |=> $stable(vld_q), "pipe moved during stall")
  `PWL_ASSERT(a_wr_sticky, (($past(wr_q) & ~wr_q) == '0), "store written bit cleared")
  `PWL_ASSERT(a_seg_sane, vld_q[StgH] |-> ((h_x_q <= h_d_q) && (h_d_q != '0)), "bad segment setup")
  `PWL_ASSERT(a_div_rem, vld_q[NumStg-1] |-> (k_rem_q[DivStg-1][0] < NumW'(k_d_q[DivStg-1])), "divide remainder too large")

endmodule

// ----- hw/rtl/pwl_lut_ram.sv -----
// Generic RAM: one write port, two registered read ports with read enable.
// No dependencies.
`timescale 1ns / 1ps

module pwl_lut_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- sim/piecewise_linear_lut_eval_tb.sv -----
// Testbench for piecewise_linear_lut_eval: node loads, node_count settings and
// evaluate items checked against an in-bench predictor of the interpolation.
// Depends on pwl_lut_pkg and the piecewise_linear_lut_eval RTL.
`timescale 1ns / 1ps

module piecewise_linear_lut_eval_tb;
  import pwl_lut_pkg::*;

  localparam int unsigned NodeSlots  = 16;
  localparam int unsigned TblWidth   = 512;
  localparam int unsigned Latency    = 14;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    col_t [NumCh-1:0] col;
  } color_entry_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CountW-1:0] cfg_node_count_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic opcode_i = 1'b0;
  logic [SlotW-1:0] node_slot_i = '0;
  logic [PosW-1:0] node_pos_i = '0;
  logic [ColW-1:0] node_red_i = '0, node_green_i = '0, node_blue_i = '0, node_alpha_i = '0;
  logic [IdxW-1:0] entry_index_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [IdxW-1:0] out_index_o;
  logic [ColW-1:0] out_red_o, out_green_o, out_blue_o, out_alpha_o;

  piecewise_linear_lut_eval u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_node_count_i,
    .in_valid_i, .in_ready_o, .opcode_i, .node_slot_i, .node_pos_i,
    .node_red_i, .node_green_i, .node_blue_i, .node_alpha_i, .entry_index_i,
    .out_valid_o, .out_ready_i, .out_index_o, .out_red_o, .out_green_o,
    .out_blue_o, .out_alpha_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  node_t            node_mem [NodeSlots];
  logic [CountW-1:0] count_reg;
  color_entry_t     color_q[$];
  int unsigned      errors = 0;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      quiet_cycles = 0;

  function automatic color_entry_t interp_color(logic [IdxW-1:0] idx);
    color_entry_t r;
    longint unsigned t, d, x, v;
    int unsigned n, k, p0, p1;
    t = (longint'(idx) * 65535) / (TblWidth - 1);
    if (t > 65535) t = 65535;
    n = 32'(count_reg);
    if (n < 2) n = 2;
    if (n > NodeSlots) n = NodeSlots;
    k = n - 2;
    for (int j = 0; j + 1 < n; j++) begin
      if (t <= node_mem[j+1].pos) begin
        k = j;
        break;
      end
    end
    p0 = 32'(node_mem[k].pos);
    p1 = 32'(node_mem[k+1].pos);
    r.idx = idx;
    for (int c = 0; c < NumCh; c++) begin
      if (p1 <= p0) begin
        r.col[c] = node_mem[k+1].col[c];
      end else begin
        d = p1 - p0;
        x = (t <= p0) ? 0 : t - p0;
        if (x > d) x = d;
        v = (longint'(node_mem[k].col[c]) * (d - x) + longint'(node_mem[k+1].col[c]) * x) / d;
        r.col[c] = v[7:0];
      end
    end
    return r;
  endfunction

  // Valid stays high after a transfer until the next item or an idle cycle.
  task automatic send_item(op_e op, logic [SlotW-1:0] slot, logic [PosW-1:0] pos,
                           logic [31:0] rgba, logic [IdxW-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    node_slot_i   <= slot;
    node_pos_i    <= pos;
    node_red_i    <= rgba[7:0];
    node_green_i  <= rgba[15:8];
    node_blue_i   <= rgba[23:16];
    node_alpha_i  <= rgba[31:24];
    entry_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OpLoad) begin
      node_mem[slot].pos = pos;
      node_mem[slot].col = {rgba[31:24], rgba[23:16], rgba[15:8], rgba[7:0]};
    end else begin
      color_q.insert(color_q.size(), interp_color(idx));
    end
    @(negedge clk_i);
  endtask

  task automatic load_node(int slot, int pos, logic [31:0] rgba);
    send_item(OpLoad, SlotW'(slot), PosW'(pos), rgba, IdxW'($urandom));
  endtask

  task automatic eval_entry(int idx);
    send_item(OpEval, SlotW'($urandom), PosW'($urandom), $urandom, IdxW'(idx));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (color_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic write_count(logic [CountW-1:0] val);
    drain();
    cfg_valid_i      <= 1'b1;
    cfg_node_count_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    count_reg = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Sorted node set with random colors; ends at 1.0 unless told otherwise.
  task automatic load_sorted(int n, bit to_one);
    int unsigned p;
    p = 0;
    for (int s = 0; s < n; s++) begin
      if (s == n - 1 && to_one) p = 65535;
      load_node(s, p, $urandom);
      p = p + $urandom_range(65535 / n);
      if (p > 65535) p = 65535;
    end
  endtask

  task automatic test_reset_table();
    eval_entry(0);
    eval_entry(511);
    eval_entry(256);
    eval_entry(1);
  endtask

  task automatic test_directed();
    load_node(0, 0, 32'h0000_00FF);
    load_node(1, 16'h8000, 32'hFF00_FF00);
    load_node(2, 16'h8000, 32'h00FF_0000);
    load_node(3, 16'hFFFF, 32'hFFFF_FFFF);
    write_count(5'd4);
    eval_entry(0);
    eval_entry(255);
    eval_entry(256);
    eval_entry(511);
    load_node(0, 16'h4000, 32'h1234_5678);
    eval_entry(10);
    load_node(3, 16'h9000, 32'hAAAA_AAAA);
    eval_entry(400);
    write_count(5'd0);
    eval_entry(100);
    write_count(5'd31);
    eval_entry(500);
    load_node(15, 16'h1000, 32'h5555_5555);
    eval_entry(300);
  endtask

  task automatic test_random(int items);
    int unsigned r;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (r < 5) load_sorted($urandom_range(2, 16), 1'($urandom_range(1)));
      else if (r < 15) load_node($urandom_range(15), $urandom, $urandom);
      else eval_entry((r < 20) ? (($urandom_range(1)) ? 511 : 0) : $urandom_range(511));
    end
  endtask

  task automatic run_phase(int sidle, int rstall, int items);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    write_count(CountW'($urandom_range(31)));
    load_sorted($urandom_range(2, 16), 1'b1);
    test_random(items);
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    color_entry_t got, exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.idx = out_index_o;
      got.col = {out_alpha_o, out_blue_o, out_green_o, out_red_o};
      if (color_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        exp = color_q.pop_front();
        if (got.idx !== exp.idx) begin
          errors++;
          $display("%0t: index exp %0d got %0d", $time, exp.idx, got.idx);
        end
        for (int c = 0; c < NumCh; c++) begin
          if (got.col[c] !== exp.col[c]) begin
            errors++;
            $display("%0t: idx %0d ch %0d exp %0d got %0d", $time, exp.idx, c,
                     exp.col[c], got.col[c]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("piecewise_linear_lut_eval_tb NOT OK");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < NodeSlots; s++) node_mem[s] = node_reset(s == 1);
    count_reg = CountReset;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_table();
    test_directed();
    run_phase(0, 0, 100);
    run_phase(49, 0, 100);
    run_phase(0, 49, 100);
    run_phase(15, 15, 100);
    recv_stall_pct = 0;
    drain();
    if (errors == 0 && color_q.size() == 0) begin
      $display("piecewise_linear_lut_eval_tb OK");
    end else begin
      $display("piecewise_linear_lut_eval_tb NOT OK");
    end
    $finish;
  end

endmodule
